// File: rtl/sem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared constants, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 13;
    localparam int PIX_W      = 24;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CFG_W      = 13;
    localparam int ROOT_STEPS = 8;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_UPDATE = 7'b0000010,
        ST_GRAD   = 7'b0000100,
        ST_SQUARE = 7'b0001000,
        ST_SUM    = 7'b0010000,
        ST_ROOT   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic grad;
        logic square;
        logic sum;
        logic root_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/sem_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/sem_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude controller
// Sequences one transaction through window update and, when a result is due,
// gradient, square, sum, square root and output load.
// ----------------------------------------------------------------------------
module sem_ctrl
    import sem_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam int CNT_W = $clog2(ROOT_STEPS);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.emit ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/sem_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude datapath
// Row stores, 3x3 window, frame position, gradients, squares, iterative
// rounded square root per channel and the output register.
// ----------------------------------------------------------------------------
module sem_datapath
    import sem_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dp_cmd_t          cmd,
    output dp_status_t            status,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             s_cmd,
    input  wire logic [7:0]       s_in_red,
    input  wire logic [7:0]       s_in_green,
    input  wire logic [7:0]       s_in_blue,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_red,
    output logic [7:0]            m_out_green,
    output logic [7:0]            m_out_blue,
    output logic                  m_row_end,
    output logic                  m_frame_end
);

    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    logic [FW_W-1:0]  w_used;
    logic [FH_W-1:0]  h_used;

    logic             cmd_reg;
    logic [PIX_W-1:0] px_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] win_next [9];
    logic [PIX_W-1:0] ew_reg [9];
    logic [PIX_W-1:0] ew_next [9];
    logic             row_end_reg;
    logic             frame_end_reg;
    logic             m_valid_reg;

    logic [PIX_W-1:0] up_rdata, mid_rdata;
    logic [PIX_W-1:0] top, mid, bottom;
    logic             pixel_phase, ignore, col_zero, emit, commit, restart;
    logic [FW_W-1:0]  c_inc, c_nx;
    logic             wrap;
    logic [ROW_W:0]   r_nx;

    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];
    logic [19:0]        sqx_reg [3];
    logic [19:0]        sqy_reg [3];
    logic [15:0]        nsh_reg [3];
    logic [10:0]        rem_reg [3];
    logic [7:0]         q_reg [3];
    logic               sat_reg [3];
    logic [7:0]         out_reg [3];

    assign w_used = (fw_reg == '0) ? FW_W'(1) :
                    (fw_reg > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_reg;
    assign h_used = (fh_reg == '0) ? FH_W'(1) :
                    (fh_reg > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_reg;

    assign pixel_phase = row_reg < h_used;
    assign ignore      = cmd_reg && pixel_phase;
    assign bottom      = pixel_phase ? px_reg : '0;
    assign top         = (row_reg >= ROW_W'(2)) ? up_rdata : '0;
    assign mid         = (row_reg >= ROW_W'(1) && row_reg <= h_used) ? mid_rdata : '0;
    assign col_zero    = (col_reg == '0);
    assign emit        = !ignore && (col_zero ? (row_reg >= ROW_W'(2))
                                              : (row_reg >= ROW_W'(1)));
    assign commit      = cmd.update && !ignore;

    assign c_inc = {1'b0, col_reg} + FW_W'(1);
    assign wrap  = c_inc >= w_used;
    assign c_nx  = wrap ? '0 : c_inc;
    assign r_nx  = {1'b0, row_reg} + (ROW_W+1)'(wrap);
    assign restart = ((w_used != FW_W'(1)) && (r_nx == {1'b0, h_used} + (ROW_W+1)'(1))
                      && (c_nx == FW_W'(1)))
                  || ((w_used == FW_W'(1)) && (r_nx == {1'b0, h_used} + (ROW_W+1)'(2)));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (col_zero) begin
                win_next[i*3]   = '0;
                win_next[i*3+1] = '0;
                ew_next[i*3]    = win_reg[i*3+1];
                ew_next[i*3+1]  = win_reg[i*3+2];
                ew_next[i*3+2]  = '0;
            end else begin
                win_next[i*3]   = win_reg[i*3+1];
                win_next[i*3+1] = win_reg[i*3+2];
                ew_next[i*3]    = win_reg[i*3+1];
                ew_next[i*3+1]  = win_reg[i*3+2];
                ew_next[i*3+2]  = '0;
            end
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = bottom;
        if (!col_zero) begin
            for (int j = 0; j < 9; j++) begin
                ew_next[j] = win_next[j];
            end
        end
    end

    sem_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (col_reg),
        .wdata (mid_rdata),
        .raddr (col_reg),
        .rdata (up_rdata)
    );

    sem_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (col_reg),
        .wdata (bottom),
        .raddr (col_reg),
        .rdata (mid_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg      <= FW_W'(640);
            fh_reg      <= FH_W'(480);
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < 9; j++) begin
                win_reg[j] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                    default:          fw_reg <= fw_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
                for (int j = 0; j < 9; j++) begin
                    win_reg[j] <= '0;
                end
            end else if (commit) begin
                if (restart) begin
                    col_reg <= '0;
                    row_reg <= '0;
                    for (int j = 0; j < 9; j++) begin
                        win_reg[j] <= '0;
                    end
                end else begin
                    col_reg <= c_nx[COL_W-1:0];
                    row_reg <= r_nx[ROW_W-1:0];
                    for (int j = 0; j < 9; j++) begin
                        win_reg[j] <= win_next[j];
                    end
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg <= s_cmd;
            px_reg  <= {s_in_red, s_in_green, s_in_blue};
        end
        if (cmd.update) begin
            for (int j = 0; j < 9; j++) begin
                ew_reg[j] <= ew_next[j];
            end
            row_end_reg   <= col_zero;
            frame_end_reg <= col_zero && ({1'b0, row_reg} == {1'b0, h_used} + (ROW_W+1)'(1));
        end
        for (int k = 0; k < 3; k++) begin
            if (cmd.grad) begin
                gx_reg[k] <= $signed({1'b0, 10'(ew_reg[2][23-8*k -: 8])
                                           + 10'({ew_reg[5][23-8*k -: 8], 1'b0})
                                           + 10'(ew_reg[8][23-8*k -: 8])})
                           - $signed({1'b0, 10'(ew_reg[0][23-8*k -: 8])
                                           + 10'({ew_reg[3][23-8*k -: 8], 1'b0})
                                           + 10'(ew_reg[6][23-8*k -: 8])});
                gy_reg[k] <= $signed({1'b0, 10'(ew_reg[6][23-8*k -: 8])
                                           + 10'({ew_reg[7][23-8*k -: 8], 1'b0})
                                           + 10'(ew_reg[8][23-8*k -: 8])})
                           - $signed({1'b0, 10'(ew_reg[0][23-8*k -: 8])
                                           + 10'({ew_reg[1][23-8*k -: 8], 1'b0})
                                           + 10'(ew_reg[2][23-8*k -: 8])});
            end
            if (cmd.square) begin
                sqx_reg[k] <= 20'($unsigned(22'(gx_reg[k] * gx_reg[k])));
                sqy_reg[k] <= 20'($unsigned(22'(gy_reg[k] * gy_reg[k])));
            end
            if (cmd.sum) begin
                sat_reg[k] <= (21'(sqx_reg[k]) + 21'(sqy_reg[k])) > 21'd65280;
                nsh_reg[k] <= 16'(21'(sqx_reg[k]) + 21'(sqy_reg[k]));
                rem_reg[k] <= '0;
                q_reg[k]   <= '0;
            end
            if (cmd.root_step) begin
                if ({rem_reg[k][8:0], nsh_reg[k][15:14]} >= {1'b0, q_reg[k], 2'b01}) begin
                    rem_reg[k] <= {rem_reg[k][8:0], nsh_reg[k][15:14]}
                                - {1'b0, q_reg[k], 2'b01};
                    q_reg[k]   <= {q_reg[k][6:0], 1'b1};
                end else begin
                    rem_reg[k] <= {rem_reg[k][8:0], nsh_reg[k][15:14]};
                    q_reg[k]   <= {q_reg[k][6:0], 1'b0};
                end
                nsh_reg[k] <= {nsh_reg[k][13:0], 2'b00};
            end
            if (cmd.load_out) begin
                if (sat_reg[k]) begin
                    out_reg[k] <= 8'd255;
                end else if (rem_reg[k] > {3'b000, q_reg[k]}) begin
                    out_reg[k] <= q_reg[k] + 8'd1;
                end else begin
                    out_reg[k] <= q_reg[k];
                end
            end
        end
        if (cmd.load_out) begin
            m_row_end   <= row_end_reg;
            m_frame_end <= frame_end_reg;
        end
    end

    assign status.emit     = emit;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_out_red       = out_reg[0];
    assign m_out_green     = out_reg[1];
    assign m_out_blue      = out_reg[2];

endmodule
`default_nettype wire

// File: rtl/sobel_edge_magnitude_rgb_core.sv
`default_nettype none
// An item that gives no result goes through the window update and back to ready.
// An item that gives a result goes through update, gradient, square, sum, square root
// and output load; the load waits for a free output register. The root runs 8 steps.
// Reset returns frame width 640, height 480, and clears position and window;
// the row stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Sobel edge magnitude core
// Streaming 3x3 Sobel gradient magnitude on RGB pixels in raster order.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_core
    import sem_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_cmd,
    input  wire logic [7:0]       s_in_red,
    input  wire logic [7:0]       s_in_green,
    input  wire logic [7:0]       s_in_blue,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_red,
    output logic [7:0]            m_out_green,
    output logic [7:0]            m_out_blue,
    output logic                  m_row_end,
    output logic                  m_frame_end
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sem_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_cmd       (s_cmd),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

endmodule
`default_nettype wire
